// File: rtl/bfd_pkg.sv
`timescale 1ns / 1ps
package bfd_pkg;

    localparam int CFG_IW  = 3;
    localparam int CFG_DW  = 28;
    localparam int SRC_W   = 12;
    localparam int OUTW_W  = 11;
    localparam int OUTH_W  = 12;
    localparam int STEP_W  = 28;
    localparam int POSX_W  = 12;
    localparam int COL_W   = 13;
    localparam int POSY_W  = 23;
    localparam int FS_W    = 12;
    localparam int CNT_W   = 23;
    localparam int SUM_W   = 32;
    localparam int CH_W    = 8;
    localparam int WORD_W  = 32;

    localparam logic [CFG_IW-1:0] CFG_MODE   = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_SRC_W  = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_OUT_W  = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_OUT_H  = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_STEP_X = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_STEP_Y = 3'd5;

    localparam logic MODE_RGB = 1'b0;
    localparam logic MODE_YUV = 1'b1;

    localparam logic [15:0] ALPHA_BIT = 16'h8000;

    typedef logic [2:0][SUM_W-1:0] sum3_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RMW,
        ST_DIV,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic            first;
        logic            fin;
        logic            last_col;
        logic            fend;
        logic            odd;
        logic [CH_W-1:0] a;
        logic [CH_W-1:0] b;
        logic [CH_W-1:0] d;
    } job_t;

endpackage

// File: rtl/bfd_ram.sv
`timescale 1ns / 1ps
module bfd_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 1024
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// File: rtl/bfd_div3.sv
`timescale 1ns / 1ps
module bfd_div3 (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  bfd_pkg::sum3_t                num,
    input  logic [bfd_pkg::CNT_W-1:0]     divisor,
    output logic                          done,
    output bfd_pkg::sum3_t                quot
);
    import bfd_pkg::*;

    localparam int CW = $clog2(SUM_W);

    sum3_t                  q_reg, q_next;
    logic [2:0][CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]       div_reg;
    logic [CW-1:0]          cnt_reg;
    logic                   busy_reg;
    logic                   done_reg;

    // one quotient bit per cycle, restoring
    always_comb
    begin
        logic [CNT_W:0] t;
        logic           ge;
        for (int i = 0; i < 3; i++)
        begin
            t  = {rem_reg[i], q_reg[i][SUM_W-1]};
            ge = t >= {1'b0, div_reg};
            rem_next[i] = ge ? CNT_W'(t - {1'b0, div_reg}) : t[CNT_W-1:0];
            q_next[i]   = {q_reg[i][SUM_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CW'(SUM_W - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(SUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= num;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg   <= q_next;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign quot = q_reg;
endmodule

// File: rtl/box_filter_image_downscaler_core.sv
`timescale 1ns / 1ps
// pixel outside every window: accepted, no ram access; pixel inside a window: ram read, write back
// pixel closing a window: read, write back, shared divider, emit state loads the output register
// one pixel in flight at a time; the output register lets the next pixel in while a beat waits
// reset: async active low, control and config registers at defaults, then a ram clearing pass
// over all MAX_OUT_WIDTH entries during which no pixel is taken (config writes still are)
module box_filter_image_downscaler_core #(
    parameter int MAX_OUT_WIDTH = 1024,
    parameter int FRAC_BITS     = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [31:0]                   s_axis_tdata,  // pixel_value, chroma_u, chroma_v
    input  logic                          s_axis_tuser,  // frame_start
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [31:0]                   m_axis_tdata,  // out_word
    output logic                          m_axis_tlast,  // row_end
    output logic                          m_axis_tuser,  // frame_end
    input  logic                          cfg_we,
    input  logic [bfd_pkg::CFG_IW-1:0]    cfg_index,
    input  logic [bfd_pkg::CFG_DW-1:0]    cfg_data
);
    import bfd_pkg::*;

    localparam int AW  = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
    localparam int SXW = FRAC_BITS + 12;
    localparam int CLW = (SXW > STEP_W) ? SXW : STEP_W;
    localparam int WXW = FRAC_BITS + COL_W;
    localparam int WYW = FRAC_BITS + POSY_W + 1;
    localparam int YIW = POSY_W + 1;
    localparam logic [COL_W-1:0] MAXW = COL_W'(MAX_OUT_WIDTH);

    // configuration
    logic              mode_reg;
    logic [SRC_W-1:0]  srcw_reg;
    logic [OUTW_W-1:0] outw_reg;
    logic [OUTH_W-1:0] outh_reg;
    logic [STEP_W-1:0] stepx_reg;
    logic [STEP_W-1:0] stepy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_RGB;
            srcw_reg  <= SRC_W'(640);
            outw_reg  <= OUTW_W'(320);
            outh_reg  <= OUTH_W'(240);
            stepx_reg <= STEP_W'(131072);
            stepy_reg <= STEP_W'(131072);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MODE:   mode_reg  <= cfg_data[0];
                CFG_SRC_W:  srcw_reg  <= cfg_data[SRC_W-1:0];
                CFG_OUT_W:  outw_reg  <= cfg_data[OUTW_W-1:0];
                CFG_OUT_H:  outh_reg  <= cfg_data[OUTH_W-1:0];
                CFG_STEP_X: stepx_reg <= cfg_data[STEP_W-1:0];
                CFG_STEP_Y: stepy_reg <= cfg_data[STEP_W-1:0];
                default:    ;
            endcase
        end
    end

    // derived settings
    logic [CLW-1:0]   lo_step, hi_step, stx_w, sty_w;
    logic [SXW-1:0]   sx_step, sy_step;
    logic [FS_W-1:0]  fsx, fsy;
    logic [SRC_W-1:0] sw;
    logic [COL_W-1:0] effw;

    always_comb
    begin
        lo_step = CLW'(1) << FRAC_BITS;
        hi_step = CLW'(2048) << FRAC_BITS;
        stx_w   = CLW'(stepx_reg);
        sty_w   = CLW'(stepy_reg);
        sx_step = SXW'((stx_w < lo_step) ? lo_step : ((stx_w > hi_step) ? hi_step : stx_w));
        sy_step = SXW'((sty_w < lo_step) ? lo_step : ((sty_w > hi_step) ? hi_step : sty_w));
        fsx     = sx_step[SXW-1:FRAC_BITS];
        fsy     = sy_step[SXW-1:FRAC_BITS];
        sw      = (srcw_reg == '0) ? SRC_W'(1) : srcw_reg;
        effw    = ({2'b00, outw_reg} < MAXW) ? {2'b00, outw_reg} : MAXW;
    end

    // position state
    logic [POSX_W-1:0] srcx_reg, srcx_next;
    logic [POSY_W-1:0] srcy_reg, srcy_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [OUTH_W-1:0] row_reg, row_next;
    logic [WXW-1:0]    wx_reg, wx_next;
    logic [WYW-1:0]    wy_reg, wy_next;
    logic              act_reg, act_next;

    state_t state_reg, state_next;
    logic   acc;

    logic              fs, e_act;
    logic [POSX_W-1:0] e_sx;
    logic [POSY_W-1:0] e_sy;
    logic [COL_W-1:0]  e_col;
    logic [OUTH_W-1:0] e_row;
    logic [WXW-1:0]    e_wx;
    logic [WYW-1:0]    e_wy;
    logic [YIW-1:0]    y0, dy;
    logic [COL_W-1:0]  x0, dx;
    logic              in_rows, last_row, in_x, hit, first, xend, last_col, fend, row_wrap;
    logic [15:0]       pix;
    job_t              job_in;

    always_comb
    begin
        fs    = s_axis_tuser;
        e_act = fs ? (outh_reg != '0) : act_reg;
        e_sx  = fs ? '0 : srcx_reg;
        e_sy  = fs ? '0 : srcy_reg;
        e_col = fs ? '0 : col_reg;
        e_row = fs ? '0 : row_reg;
        e_wx  = fs ? '0 : wx_reg;
        e_wy  = fs ? '0 : wy_reg;

        y0       = e_wy[WYW-1:FRAC_BITS];
        dy       = {1'b0, e_sy} - y0;
        in_rows  = ({1'b0, e_sy} >= y0) && (dy < YIW'(fsy));
        last_row = in_rows && (dy == YIW'(fsy) - YIW'(1));
        x0       = e_wx[WXW-1:FRAC_BITS];
        dx       = {1'b0, e_sx} - x0;
        in_x     = ({1'b0, e_sx} >= x0) && (dx < COL_W'(fsx));
        hit      = e_act && in_rows && (e_col < effw) && in_x;
        first    = ({1'b0, e_sy} == y0) && ({1'b0, e_sx} == x0);
        xend     = hit && (dx == COL_W'(fsx) - COL_W'(1));
        last_col = e_col == effw - COL_W'(1);
        fend     = last_col && (e_row == outh_reg - OUTH_W'(1));
        row_wrap = e_sx >= sw - SRC_W'(1);

        pix             = s_axis_tdata[15:0];
        job_in.first    = first;
        job_in.fin      = xend && last_row;
        job_in.last_col = last_col;
        job_in.fend     = fend;
        job_in.odd      = e_col[0];
        if (mode_reg == MODE_RGB)
        begin
            job_in.a = CH_W'(pix[14:10]);
            job_in.b = CH_W'(pix[9:5]);
            job_in.d = CH_W'(pix[4:0]);
        end
        else
        begin
            job_in.a = pix[7:0];
            job_in.b = s_axis_tdata[23:16];
            job_in.d = s_axis_tdata[31:24];
        end
    end

    always_comb
    begin
        srcx_next = srcx_reg;
        srcy_next = srcy_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        wx_next   = wx_reg;
        wy_next   = wy_reg;
        act_next  = act_reg;
        if (acc)
        begin
            srcx_next = e_sx;
            srcy_next = e_sy;
            col_next  = e_col;
            row_next  = e_row;
            wx_next   = e_wx;
            wy_next   = e_wy;
            act_next  = e_act;
            if (e_act)
            begin
                if (xend)
                begin
                    col_next = e_col + COL_W'(1);
                    wx_next  = e_wx + WXW'(sx_step);
                end
                if (row_wrap)
                begin
                    srcx_next = '0;
                    col_next  = '0;
                    wx_next   = '0;
                    if (last_row)
                    begin
                        row_next = e_row + OUTH_W'(1);
                        wy_next  = e_wy + WYW'(sy_step);
                        if (({1'b0, e_row} + 13'd1) >= {1'b0, outh_reg})
                        begin
                            act_next = 1'b0;
                        end
                    end
                    srcy_next = e_sy + POSY_W'(1);
                end
                else
                begin
                    srcx_next = e_sx + POSX_W'(1);
                end
            end
        end
    end

    // job, memory and divider
    job_t            job_reg;
    logic [AW-1:0]   jcol_reg;
    logic [AW-1:0]   clr_reg;
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [3*SUM_W-1:0] ram_wdata, ram_rdata;
    sum3_t           new_sum, quot;
    logic            div_start, div_done;
    logic [WORD_W-1:0] pend_reg, even_word, out_word;
    logic            emit, out_free, out_load, pend_we;
    logic            m_valid_reg, m_last_reg, m_user_reg;
    logic [WORD_W-1:0] m_data_reg;

    always_comb
    begin
        new_sum[0] = job_reg.first ? SUM_W'(job_reg.a) : ram_rdata[SUM_W-1:0] + SUM_W'(job_reg.a);
        new_sum[1] = job_reg.first ? SUM_W'(job_reg.b)
                                   : ram_rdata[2*SUM_W-1:SUM_W] + SUM_W'(job_reg.b);
        new_sum[2] = job_reg.first ? SUM_W'(job_reg.d)
                                   : ram_rdata[3*SUM_W-1:2*SUM_W] + SUM_W'(job_reg.d);
    end

    bfd_ram #(
        .WIDTH (3 * SUM_W),
        .DEPTH (MAX_OUT_WIDTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (e_col[AW-1:0]),
        .rdata (ram_rdata)
    );

    bfd_div3 u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .num     (new_sum),
        .divisor (CNT_W'(fsx * fsy)),
        .done    (div_done),
        .quot    (quot)
    );

    always_comb
    begin
        even_word = {quot[2][7:0], 8'h00, quot[1][7:0], quot[0][7:0]};
        if (mode_reg == MODE_RGB)
        begin
            out_word = {16'h0000, ALPHA_BIT | {1'b0, quot[0][4:0], quot[1][4:0], quot[2][4:0]}};
            emit     = 1'b1;
        end
        else if (!job_reg.odd)
        begin
            out_word = even_word;
            emit     = job_reg.last_col;
        end
        else
        begin
            // odd column completes the pair held from its even neighbor
            out_word = pend_reg | {8'h00, quot[0][7:0], 16'h0000};
            emit     = 1'b1;
        end
        out_free = !m_valid_reg || m_axis_tready;
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == AW'(MAX_OUT_WIDTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (acc && hit)
                begin
                    state_next = ST_RMW;
                end
            end
            ST_RMW:  state_next = job_reg.fin ? ST_DIV : ST_IDLE;
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!emit || out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_axis_tready = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = jcol_reg;
        ram_wdata     = new_sum;
        div_start     = 1'b0;
        out_load      = 1'b0;
        pend_we       = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
            end
            ST_IDLE: s_axis_tready = 1'b1;
            ST_RMW:
            begin
                ram_we    = 1'b1;
                div_start = job_reg.fin;
            end
            ST_DIV:  ;
            ST_EMIT:
            begin
                out_load = emit && out_free;
                pend_we  = (mode_reg == MODE_YUV) && !job_reg.odd;
            end
            default: ;
        endcase
    end

    assign acc = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            srcx_reg    <= '0;
            srcy_reg    <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
            wx_reg      <= '0;
            wy_reg      <= '0;
            act_reg     <= 1'b0;
            pend_reg    <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            srcx_reg <= srcx_next;
            srcy_reg <= srcy_next;
            col_reg  <= col_next;
            row_reg  <= row_next;
            wx_reg   <= wx_next;
            wy_reg   <= wy_next;
            act_reg  <= act_next;
            if (pend_we)
            begin
                pend_reg <= even_word;
            end
            if (out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            job_reg  <= job_in;
            jcol_reg <= e_col[AW-1:0];
        end
        if (out_load)
        begin
            m_data_reg <= out_word;
            m_last_reg <= job_reg.last_col;
            m_user_reg <= job_reg.fend;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tuser  = m_user_reg;

    a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide state");

    a_rmw_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RMW) |-> $past(s_axis_tvalid && s_axis_tready))
        else $error("read-modify-write without an accepted beat");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> m_axis_tvalid)
        else $error("loaded result not presented");

    a_frame_end_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
        else $error("frame end without row end");

endmodule
